// ----- hdl/fcs_pkg.sv -----
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants of the fill and cap station sequencer.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int FILL_DELAY_TICKS = 50;
    localparam int CFG_IDX_BITS     = 3;
    localparam int CFG_DATA_BITS    = 16;
    localparam int JARS_BITS        = 8;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PAUSED  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_CENTER = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        FILL_IDLE      = 3'd0,
        FILL_WAIT      = 3'd1,
        FILL_CENTERING = 3'd2,
        FILL_PISTON    = 3'd3,
        FILL_DELAY     = 3'd4
    } t_fill_ph;

    typedef enum logic [2:0] {
        CAP_IDLE        = 3'd0,
        CAP_WAIT        = 3'd1,
        CAP_SCREW_ON    = 3'd2,
        CAP_SCREW_PAUSE = 3'd3,
        CAP_CLOSE       = 3'd4,
        CAP_CLOSE_PAUSE = 3'd5
    } t_cap_ph;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PISTON_HOLD   = 3'd0,
        CFG_SCREW_PAUSE   = 3'd1,
        CFG_CLOSE_HOLD    = 3'd2,
        CFG_CLOSE_PAUSE   = 3'd3,
        CFG_JARS_PER_SET  = 3'd4,
        CFG_RELEASE_PULSE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] piston_hold_ms;
        logic [CFG_DATA_BITS-1:0] screw_pause_ms;
        logic [CFG_DATA_BITS-1:0] close_hold_ms;
        logic [CFG_DATA_BITS-1:0] close_pause_ms;
        logic [JARS_BITS-1:0]     jars_per_set;
        logic [CFG_DATA_BITS-1:0] release_pulse_ms;
    } t_cfg;

    typedef struct packed {
        logic start_pressed;
        logic stop_pressed;
        logic fill_sensor_edge;
        logic cap_sensor_edge;
        logic belt_running;
        logic centering_active;
    } t_item;

    typedef struct packed {
        logic [1:0] machine_mode;
        logic [1:0] belt_command;
        logic       release_valve_on;
        logic       piston_valve_on;
        logic       screw_valve_on;
        logic       close_valve_on;
        logic [2:0] fill_phase;
        logic [2:0] cap_phase;
    } t_result;

endpackage

// ----- hdl/fill_and_cap_station_sequencer.sv -----
// ----------------------------------------------------------------------------
// fill_and_cap_station_sequencer
// Millisecond tick sequencer for a jar fill and cap station.
// ----------------------------------------------------------------------------
// One input word per tick carries the button presses, sensor edges and belt
// status; one result word per tick carries the machine mode, belt command,
// valve levels and both sequence phases. Both channels move a word at an
// edge where valid is high and stall is low.
// A word passes an input register, the update logic and a result register:
// the result shows on o_valid from the result register and is taken at an
// edge where i_stall is low. A new word is taken every cycle while o_stall
// is low, each in one pass (one tick of all counters and both sequences).
// When the result side stalls, the result register holds and the input
// register fills; o_stall then rises until the result is taken.
// The configuration port is always ready and takes a register index and
// data; writes to indexes beyond the register list are ignored.
// Synchronous reset puts the machine stopped, both sequences idle, all
// countdowns at zero and the registers at their default values.
// ----------------------------------------------------------------------------
module fill_and_cap_station_sequencer
    import fcs_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_start_pressed,
    input  logic                     i_stop_pressed,
    input  logic                     i_fill_sensor_edge,
    input  logic                     i_cap_sensor_edge,
    input  logic                     i_belt_running,
    input  logic                     i_centering_active,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_machine_mode,
    output logic [1:0]               o_belt_command,
    output logic                     o_release_valve_on,
    output logic                     o_piston_valve_on,
    output logic                     o_screw_valve_on,
    output logic                     o_close_valve_on,
    output logic [2:0]               o_fill_phase,
    output logic [2:0]               o_cap_phase,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result result;
    logic    advance;
    logic    fire;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    fcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    fcs_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.start_pressed    <= i_start_pressed;
            r_in.stop_pressed     <= i_stop_pressed;
            r_in.fill_sensor_edge <= i_fill_sensor_edge;
            r_in.cap_sensor_edge  <= i_cap_sensor_edge;
            r_in.belt_running     <= i_belt_running;
            r_in.centering_active <= i_centering_active;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_machine_mode     = r_out.machine_mode;
    assign o_belt_command     = r_out.belt_command;
    assign o_release_valve_on = r_out.release_valve_on;
    assign o_piston_valve_on  = r_out.piston_valve_on;
    assign o_screw_valve_on   = r_out.screw_valve_on;
    assign o_close_valve_on   = r_out.close_valve_on;
    assign o_fill_phase       = r_out.fill_phase;
    assign o_cap_phase        = r_out.cap_phase;

endmodule

// ----- hdl/fcs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// fcs_cfg_regs
// Configuration register file with its write port and reset values.
// ----------------------------------------------------------------------------
module fcs_cfg_regs
    import fcs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_cfg_ready,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.piston_hold_ms   <= 16'd1000;
            r_cfg.screw_pause_ms   <= 16'd500;
            r_cfg.close_hold_ms    <= 16'd500;
            r_cfg.close_pause_ms   <= 16'd500;
            r_cfg.jars_per_set     <= 8'd1;
            r_cfg.release_pulse_ms <= 16'd500;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PISTON_HOLD:   r_cfg.piston_hold_ms   <= i_cfg_data;
                CFG_SCREW_PAUSE:   r_cfg.screw_pause_ms   <= i_cfg_data;
                CFG_CLOSE_HOLD:    r_cfg.close_hold_ms    <= i_cfg_data;
                CFG_CLOSE_PAUSE:   r_cfg.close_pause_ms   <= i_cfg_data;
                CFG_JARS_PER_SET:  r_cfg.jars_per_set     <= i_cfg_data[JARS_BITS-1:0];
                CFG_RELEASE_PULSE: r_cfg.release_pulse_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/fcs_core.sv -----
// ----------------------------------------------------------------------------
// fcs_core
// Sequencer state and the per-tick update of mode, fill and cap sequences.
// ----------------------------------------------------------------------------
module fcs_core
    import fcs_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    t_mode                 r_mode,     n_mode;
    t_fill_ph              r_fill,     n_fill;
    t_cap_ph               r_cap,      n_cap;
    logic [JARS_BITS-1:0]  r_fskip,    n_fskip;
    logic [JARS_BITS-1:0]  r_cskip,    n_cskip;
    logic [TIMER_BITS-1:0] r_fdelay,   n_fdelay;
    logic [TIMER_BITS-1:0] r_cpause,   n_cpause;
    logic [TIMER_BITS-1:0] r_release,  n_release;
    logic [TIMER_BITS-1:0] r_piston,   n_piston;
    logic [TIMER_BITS-1:0] r_close,    n_close;
    logic                  r_screw,    n_screw;
    t_cmd                  n_cmd;
    logic                  n_belt;
    logic                  n_centering;
    logic [JARS_BITS-1:0]  skip_load;

    function automatic logic [TIMER_BITS-1:0] sat_t(input logic [CFG_DATA_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(TIMER_MAX)) begin
            return TIMER_MAX;
        end
        return TIMER_BITS'(w);
    endfunction

    assign skip_load = (i_cfg.jars_per_set != '0) ? i_cfg.jars_per_set - 8'd1 : '0;

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_fill      = r_fill;
        n_cap       = r_cap;
        n_fskip     = r_fskip;
        n_cskip     = r_cskip;
        n_fdelay    = r_fdelay;
        n_cpause    = r_cpause;
        n_release   = r_release;
        n_piston    = r_piston;
        n_close     = r_close;
        n_screw     = r_screw;
        n_cmd       = CMD_NONE;
        n_belt      = i_item.belt_running;
        n_centering = i_item.centering_active;

        // countdowns run only while running
        if (r_mode == MODE_RUNNING) begin
            if (n_release != '0) n_release = n_release - TIMER_ONE;
            if (n_piston != '0)  n_piston  = n_piston - TIMER_ONE;
            if (n_close != '0)   n_close   = n_close - TIMER_ONE;
            if (n_fdelay != '0)  n_fdelay  = n_fdelay - TIMER_ONE;
            if (n_cpause != '0)  n_cpause  = n_cpause - TIMER_ONE;
        end

        if (i_item.start_pressed) begin
            if (n_mode == MODE_PAUSED) begin
                n_mode = MODE_RUNNING;
            end else if (n_mode != MODE_RUNNING) begin
                n_mode      = MODE_RUNNING;
                n_fill      = FILL_IDLE;
                n_cap       = CAP_IDLE;
                n_fskip     = '0;
                n_cskip     = '0;
                n_cmd       = CMD_START;
                n_belt      = 1'b1;
                n_centering = 1'b0;
                n_release   = sat_t(i_cfg.release_pulse_ms);
            end
        end

        if (i_item.stop_pressed) begin
            if (n_mode == MODE_RUNNING) begin
                n_mode      = MODE_PAUSED;
                n_cmd       = CMD_STOP;
                n_belt      = 1'b0;
                n_centering = 1'b0;
            end else if (n_mode == MODE_PAUSED) begin
                n_mode      = MODE_STOPPED;
                n_fill      = FILL_IDLE;
                n_cap       = CAP_IDLE;
                n_cmd       = CMD_STOP;
                n_belt      = 1'b0;
                n_centering = 1'b0;
                n_release   = '0;
                n_piston    = '0;
                n_close     = '0;
                n_fdelay    = '0;
                n_cpause    = '0;
                n_screw     = 1'b0;
            end
        end

        if (n_mode == MODE_RUNNING) begin
            unique case (n_fill)
                FILL_WAIT: begin
                    if (i_item.fill_sensor_edge) begin
                        if (n_fskip == '0) begin
                            n_cmd       = CMD_CENTER;
                            n_centering = 1'b1;
                            n_fill      = FILL_CENTERING;
                        end else begin
                            n_fskip = n_fskip - 8'd1;
                        end
                    end
                end
                FILL_CENTERING: begin
                    if (!n_belt) begin
                        n_piston = sat_t(i_cfg.piston_hold_ms);
                        n_fill   = FILL_PISTON;
                    end
                end
                FILL_PISTON: begin
                    if (n_piston == '0) begin
                        n_fdelay = sat_t(CFG_DATA_BITS'(FILL_DELAY_TICKS));
                        n_fill   = FILL_DELAY;
                    end
                end
                FILL_DELAY: begin
                    if (n_fdelay == '0) begin
                        n_fskip   = skip_load;
                        n_fill    = FILL_WAIT;
                        n_release = sat_t(i_cfg.release_pulse_ms);
                    end
                end
                default: n_fill = FILL_WAIT;
            endcase

            unique case (n_cap)
                CAP_WAIT: begin
                    if (i_item.cap_sensor_edge) begin
                        if (n_cskip == '0) begin
                            n_cmd       = CMD_STOP;
                            n_belt      = 1'b0;
                            n_centering = 1'b0;
                            n_screw     = 1'b1;
                            n_cap       = CAP_SCREW_ON;
                        end else begin
                            n_cskip = n_cskip - 8'd1;
                        end
                    end
                end
                CAP_SCREW_ON: begin
                    n_cpause = sat_t(i_cfg.screw_pause_ms);
                    n_cap    = CAP_SCREW_PAUSE;
                end
                CAP_SCREW_PAUSE: begin
                    if (n_cpause == '0) begin
                        n_close = sat_t(i_cfg.close_hold_ms);
                        n_cap   = CAP_CLOSE;
                    end
                end
                CAP_CLOSE: begin
                    if (n_close == '0) begin
                        n_cpause = sat_t(i_cfg.close_pause_ms);
                        n_cap    = CAP_CLOSE_PAUSE;
                    end
                end
                CAP_CLOSE_PAUSE: begin
                    if (n_cpause == '0) begin
                        n_screw = 1'b0;
                        n_cskip = skip_load;
                        n_cap   = CAP_WAIT;
                    end
                end
                default: n_cap = CAP_WAIT;
            endcase

            // belt arbitration
            if (!n_centering) begin
                if ((n_fill != FILL_IDLE && n_fill != FILL_WAIT) ||
                    (n_cap != CAP_IDLE && n_cap != CAP_WAIT)) begin
                    if (n_belt) begin
                        n_cmd  = CMD_STOP;
                        n_belt = 1'b0;
                    end
                end else if (!n_belt) begin
                    n_cmd  = CMD_START;
                    n_belt = 1'b1;
                end
            end
        end
    end

    // result word
    always_comb begin
        o_result.machine_mode     = n_mode;
        o_result.belt_command     = n_cmd;
        o_result.release_valve_on = (n_release != '0);
        o_result.piston_valve_on  = (n_piston != '0);
        o_result.screw_valve_on   = n_screw;
        o_result.close_valve_on   = (n_close != '0);
        o_result.fill_phase       = n_fill;
        o_result.cap_phase        = n_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STOPPED;
            r_fill    <= FILL_IDLE;
            r_cap     <= CAP_IDLE;
            r_fskip   <= '0;
            r_cskip   <= '0;
            r_fdelay  <= '0;
            r_cpause  <= '0;
            r_release <= '0;
            r_piston  <= '0;
            r_close   <= '0;
            r_screw   <= 1'b0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_fill    <= n_fill;
            r_cap     <= n_cap;
            r_fskip   <= n_fskip;
            r_cskip   <= n_cskip;
            r_fdelay  <= n_fdelay;
            r_cpause  <= n_cpause;
            r_release <= n_release;
            r_piston  <= n_piston;
            r_close   <= n_close;
            r_screw   <= n_screw;
        end
    end

`ifndef NO_ASSERTIONS
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STOPPED |-> r_release == '0 && r_piston == '0 && r_close == '0
            && r_fdelay == '0 && r_cpause == '0 && !r_screw)
        else $error("countdown or screw valve active while stopped");

    a_piston_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_piston != '0 |-> r_fill == FILL_PISTON)
        else $error("piston valve on outside piston phase");

    a_close_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_close != '0 |-> r_cap == CAP_CLOSE)
        else $error("close valve on outside close phase");

    a_screw_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_screw |-> r_cap == CAP_SCREW_ON || r_cap == CAP_SCREW_PAUSE
            || r_cap == CAP_CLOSE || r_cap == CAP_CLOSE_PAUSE)
        else $error("screw valve on outside cap sequence");
`endif

endmodule
